[sv/aes_ctr_pkg.sv]
// AES-128 counter mode: shared types, S-box and round functions.
// No dependencies; imported by the round cell and the top level.
`default_nettype none
package aes_ctr_pkg;

  typedef struct packed {
    logic [127:0] state;
    logic [127:0] rkey;
    logic [127:0] text;
    logic [4:0]   nbytes;
  } stage_t;

  localparam logic [1:0] REG_KEY_LOW  = 2'd0;
  localparam logic [1:0] REG_KEY_HIGH = 2'd1;
  localparam logic [1:0] REG_NONCE    = 2'd2;
  localparam logic [4:0] BLOCK_BYTES  = 5'd16;

  localparam logic [7:0] RCON [10] = '{
    8'h01, 8'h02, 8'h04, 8'h08, 8'h10, 8'h20, 8'h40, 8'h80, 8'h1b, 8'h36
  };

  localparam logic [7:0] SBOX [256] = '{
    8'h63,8'h7c,8'h77,8'h7b,8'hf2,8'h6b,8'h6f,8'hc5,8'h30,8'h01,8'h67,8'h2b,8'hfe,8'hd7,8'hab,8'h76,
    8'hca,8'h82,8'hc9,8'h7d,8'hfa,8'h59,8'h47,8'hf0,8'had,8'hd4,8'ha2,8'haf,8'h9c,8'ha4,8'h72,8'hc0,
    8'hb7,8'hfd,8'h93,8'h26,8'h36,8'h3f,8'hf7,8'hcc,8'h34,8'ha5,8'he5,8'hf1,8'h71,8'hd8,8'h31,8'h15,
    8'h04,8'hc7,8'h23,8'hc3,8'h18,8'h96,8'h05,8'h9a,8'h07,8'h12,8'h80,8'he2,8'heb,8'h27,8'hb2,8'h75,
    8'h09,8'h83,8'h2c,8'h1a,8'h1b,8'h6e,8'h5a,8'ha0,8'h52,8'h3b,8'hd6,8'hb3,8'h29,8'he3,8'h2f,8'h84,
    8'h53,8'hd1,8'h00,8'hed,8'h20,8'hfc,8'hb1,8'h5b,8'h6a,8'hcb,8'hbe,8'h39,8'h4a,8'h4c,8'h58,8'hcf,
    8'hd0,8'hef,8'haa,8'hfb,8'h43,8'h4d,8'h33,8'h85,8'h45,8'hf9,8'h02,8'h7f,8'h50,8'h3c,8'h9f,8'ha8,
    8'h51,8'ha3,8'h40,8'h8f,8'h92,8'h9d,8'h38,8'hf5,8'hbc,8'hb6,8'hda,8'h21,8'h10,8'hff,8'hf3,8'hd2,
    8'hcd,8'h0c,8'h13,8'hec,8'h5f,8'h97,8'h44,8'h17,8'hc4,8'ha7,8'h7e,8'h3d,8'h64,8'h5d,8'h19,8'h73,
    8'h60,8'h81,8'h4f,8'hdc,8'h22,8'h2a,8'h90,8'h88,8'h46,8'hee,8'hb8,8'h14,8'hde,8'h5e,8'h0b,8'hdb,
    8'he0,8'h32,8'h3a,8'h0a,8'h49,8'h06,8'h24,8'h5c,8'hc2,8'hd3,8'hac,8'h62,8'h91,8'h95,8'he4,8'h79,
    8'he7,8'hc8,8'h37,8'h6d,8'h8d,8'hd5,8'h4e,8'ha9,8'h6c,8'h56,8'hf4,8'hea,8'h65,8'h7a,8'hae,8'h08,
    8'hba,8'h78,8'h25,8'h2e,8'h1c,8'ha6,8'hb4,8'hc6,8'he8,8'hdd,8'h74,8'h1f,8'h4b,8'hbd,8'h8b,8'h8a,
    8'h70,8'h3e,8'hb5,8'h66,8'h48,8'h03,8'hf6,8'h0e,8'h61,8'h35,8'h57,8'hb9,8'h86,8'hc1,8'h1d,8'h9e,
    8'he1,8'hf8,8'h98,8'h11,8'h69,8'hd9,8'h8e,8'h94,8'h9b,8'h1e,8'h87,8'he9,8'hce,8'h55,8'h28,8'hdf,
    8'h8c,8'ha1,8'h89,8'h0d,8'hbf,8'he6,8'h42,8'h68,8'h41,8'h99,8'h2d,8'h0f,8'hb0,8'h54,8'hbb,8'h16
  };

  function automatic logic [7:0] xtime(input logic [7:0] v);
    xtime = {v[6:0], 1'b0} ^ (v[7] ? 8'h1b : 8'h00);
  endfunction

  // Byte i of a block sits in bits 8i+7:8i.
  function automatic logic [127:0] sub_shift(input logic [127:0] s);
    logic [127:0] t;
    t = '0;
    for (int c = 0; c < 4; c++) begin
      for (int i = 0; i < 4; i++) begin
        t[8*(4*c+i) +: 8] = SBOX[s[8*(4*((c+i)%4)+i) +: 8]];
      end
    end
    sub_shift = t;
  endfunction

  function automatic logic [127:0] mix_columns(input logic [127:0] t);
    logic [127:0] s;
    logic [7:0] a0, a1, a2, a3, all;
    s = '0;
    for (int c = 0; c < 4; c++) begin
      a0 = t[8*(4*c)   +: 8];
      a1 = t[8*(4*c+1) +: 8];
      a2 = t[8*(4*c+2) +: 8];
      a3 = t[8*(4*c+3) +: 8];
      all = a0 ^ a1 ^ a2 ^ a3;
      s[8*(4*c)   +: 8] = a0 ^ all ^ xtime(a0 ^ a1);
      s[8*(4*c+1) +: 8] = a1 ^ all ^ xtime(a1 ^ a2);
      s[8*(4*c+2) +: 8] = a2 ^ all ^ xtime(a2 ^ a3);
      s[8*(4*c+3) +: 8] = a3 ^ all ^ xtime(a3 ^ a0);
    end
    mix_columns = s;
  endfunction

  function automatic logic [127:0] next_key(input logic [127:0] k, input logic [7:0] rc);
    logic [31:0] t;
    logic [127:0] n;
    t = {SBOX[k[103:96]], SBOX[k[127:120]], SBOX[k[119:112]], SBOX[k[111:104]] ^ rc};
    n[31:0]   = k[31:0]   ^ t;
    n[63:32]  = k[63:32]  ^ n[31:0];
    n[95:64]  = k[95:64]  ^ n[63:32];
    n[127:96] = k[127:96] ^ n[95:64];
    next_key = n;
  endfunction

endpackage
`default_nettype wire

[sv/aes_ctr_round.sv]
// One AES round cell: key schedule step, round transform, stage register.
// Depends on aes_ctr_pkg. The last cell also applies the text XOR and byte mask.
`default_nettype none
module aes_ctr_round #(
  parameter int ROUND = 1
) (
  input  wire logic              clk,
  input  wire logic              rst,
  input  wire logic              up_valid,
  output logic                   up_ready,
  input  wire aes_ctr_pkg::stage_t up_data,
  output logic                   dn_valid,
  input  wire logic              dn_ready,
  output aes_ctr_pkg::stage_t    dn_data
);
  import aes_ctr_pkg::*;

  localparam bit LAST = (ROUND == 10);

  stage_t        data_next;
  logic [127:0]  rk;
  logic [127:0]  sb;
  logic [127:0]  ks;

  always_comb begin
    rk = next_key(up_data.rkey, RCON[ROUND-1]);
    sb = sub_shift(up_data.state);
    ks = (LAST ? sb : mix_columns(sb)) ^ rk;
    data_next = up_data;
    data_next.rkey = rk;
    data_next.state = ks;
    if (LAST) begin
      // keystream XOR text; bytes at or past the count read as zero
      for (int i = 0; i < 16; i++) begin
        data_next.state[8*i +: 8] = (5'(i) < up_data.nbytes) ?
                                    (ks[8*i +: 8] ^ up_data.text[8*i +: 8]) : 8'h00;
      end
    end
  end

  assign up_ready = !dn_valid || dn_ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      dn_valid <= 1'b0;
    end else if (up_ready) begin
      dn_valid <= up_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (up_ready && up_valid) begin
      dn_data <= data_next;
    end
  end

endmodule
`default_nettype wire

[sv/aes128_ctr_keystream_xor_unit.sv]
// AES-128 CTR keystream XOR: config registers, block counter, load stage and
// a chain of ten round cells. Depends on aes_ctr_pkg and aes_ctr_round.
//
// Usage: write key_low (0), key_high (1) and nonce_value (2) through
// cfg_write/cfg_index/cfg_data while idle. Items enter on in_valid/in_ready
// with text_low/text_high/valid_bytes; new_message restarts the block counter
// at zero for that item. Each item leaves on out_valid/out_ready carrying the
// text XOR keystream, bytes past the count zeroed, and the count (saturated
// at 16; a count of zero gives an all-zero result and does not advance the counter).
// The load stage plus one register per AES round makes eleven registers, and
// out_valid rises once an item has passed through all of them. One item per
// cycle is accepted while in_ready is high; each round cell expands its own
// round key, so the key travels with the item. Every stage has its own valid
// bit and advances whenever the next is empty or moving, so a stalled receiver
// backs items up stage by stage and in_ready drops only when all are full.
// Reset clears the config registers, the counter and all stage valid bits.
`default_nettype none
module aes128_ctr_keystream_xor_unit (
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire logic        cfg_write,
  input  wire logic [1:0]  cfg_index,
  input  wire logic [63:0] cfg_data,
  input  wire logic        in_valid,
  output logic             in_ready,
  input  wire logic        new_message,
  input  wire logic [63:0] text_low,
  input  wire logic [63:0] text_high,
  input  wire logic [4:0]  valid_bytes,
  output logic             out_valid,
  input  wire logic        out_ready,
  output logic [63:0]      result_low,
  output logic [63:0]      result_high,
  output logic [4:0]       result_bytes
);
  import aes_ctr_pkg::*;

  logic [63:0] key_low;
  logic [63:0] key_high;
  logic [63:0] nonce_value;
  logic [63:0] block_counter;
  logic [63:0] block_counter_next;
  logic [63:0] ctr_used;
  logic [4:0]  nbytes;
  logic        accept;

  logic        vld   [11];
  logic        rdy   [11];
  stage_t      stg   [11];
  stage_t      load_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      key_low <= '0;
      key_high <= '0;
      nonce_value <= '0;
    end else if (cfg_write) begin
      case (cfg_index)
        REG_KEY_LOW:  key_low <= cfg_data;
        REG_KEY_HIGH: key_high <= cfg_data;
        REG_NONCE:    nonce_value <= cfg_data;
        default: ;
      endcase
    end
  end

  assign accept = in_valid && in_ready;
  assign nbytes = (valid_bytes > BLOCK_BYTES) ? BLOCK_BYTES : valid_bytes;
  assign ctr_used = new_message ? 64'd0 : block_counter;
  assign block_counter_next = (nbytes != 5'd0) ? ctr_used + 64'd1 : ctr_used;

  always_ff @(posedge clk) begin
    if (rst) begin
      block_counter <= '0;
    end else if (accept) begin
      block_counter <= block_counter_next;
    end
  end

  always_comb begin
    load_next.rkey = {key_high, key_low};
    load_next.state = {ctr_used, nonce_value} ^ {key_high, key_low};
    load_next.text = {text_high, text_low};
    load_next.nbytes = nbytes;
  end

  assign in_ready = !vld[0] || rdy[0];

  always_ff @(posedge clk) begin
    if (rst) begin
      vld[0] <= 1'b0;
    end else if (in_ready) begin
      vld[0] <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      stg[0] <= load_next;
    end
  end

  for (genvar r = 1; r <= 10; r++) begin : g_round
    aes_ctr_round #(.ROUND(r)) u_round (
      .clk      (clk),
      .rst      (rst),
      .up_valid (vld[r-1]),
      .up_ready (rdy[r-1]),
      .up_data  (stg[r-1]),
      .dn_valid (vld[r]),
      .dn_ready (rdy[r]),
      .dn_data  (stg[r])
    );
  end

  assign rdy[10] = out_ready;
  assign out_valid = vld[10];
  assign result_low = stg[10].state[63:0];
  assign result_high = stg[10].state[127:64];
  assign result_bytes = stg[10].nbytes;

  a_rst_empty: assert property (@(posedge clk) rst |=> !out_valid && !vld[0])
    else $error("pipeline not empty after reset");
  a_ctr_step: assert property (@(posedge clk) disable iff (rst)
    accept && !new_message && nbytes != 5'd0 |=> block_counter == $past(block_counter) + 64'd1)
    else $error("block counter did not advance");
  a_ctr_restart: assert property (@(posedge clk) disable iff (rst)
    accept && new_message |=> block_counter == (($past(nbytes) != 5'd0) ? 64'd1 : 64'd0))
    else $error("block counter did not restart");
  a_ctr_hold: assert property (@(posedge clk) disable iff (rst)
    !accept |=> $stable(block_counter))
    else $error("block counter moved without an item");

endmodule
`default_nettype wire

[sim/aes128_ctr_keystream_xor_unit_tb.sv]
// Testbench for the AES-128 CTR keystream XOR unit: directed table, then random
// messages, checked against an in-bench AES-128 CTR predictor. Needs aes_ctr_pkg.
`default_nettype none
module aes128_ctr_keystream_xor_unit_tb;
  timeunit 1ns;
  timeprecision 1ps;
  import aes_ctr_pkg::*;

  typedef struct {
    logic        newmsg;
    logic [63:0] lo;
    logic [63:0] hi;
    logic [4:0]  nb;
    logic        has_exp;
    logic [63:0] elo;
    logic [63:0] ehi;
    logic [4:0]  enb;
  } vec_t;

  typedef struct {
    logic [63:0] lo;
    logic [63:0] hi;
    logic [4:0]  nb;
  } res_t;

  logic clk, rst;
  logic cfg_write;
  logic [1:0] cfg_index;
  logic [63:0] cfg_data;
  logic in_valid, in_ready, new_message;
  logic [63:0] text_low, text_high;
  logic [4:0] valid_bytes;
  logic out_valid, out_ready;
  logic [63:0] result_low, result_high;
  logic [4:0] result_bytes;

  aes128_ctr_keystream_xor_unit dut (.*);

  // predictor state
  logic [7:0]  sb [256];
  logic [63:0] m_key_lo, m_key_hi, m_nonce, m_ctr;
  logic [7:0]  rks [11][16];
  res_t        pending_q [$];
  int          errors;
  int          sent;
  bit          in_done;

  function automatic logic [7:0] gmul2(input logic [7:0] v);
    return {v[6:0], 1'b0} ^ (v[7] ? 8'h1b : 8'h00);
  endfunction

  task automatic build_round_keys();
    logic [7:0] w [176];
    logic [7:0] t [4];
    logic [7:0] x;
    logic [7:0] rc;
    rc = 8'h01;
    for (int i = 0; i < 8; i++) begin
      w[i] = m_key_lo[8*i +: 8];
      w[i+8] = m_key_hi[8*i +: 8];
    end
    for (int i = 16; i < 176; i += 4) begin
      for (int r = 0; r < 4; r++) t[r] = w[i-4+r];
      if (i % 16 == 0) begin
        x = t[0];
        t[0] = sb[t[1]] ^ rc;
        t[1] = sb[t[2]];
        t[2] = sb[t[3]];
        t[3] = sb[x];
        rc = gmul2(rc);
      end
      for (int r = 0; r < 4; r++) w[i+r] = w[i-16+r] ^ t[r];
    end
    for (int r = 0; r < 11; r++)
      for (int i = 0; i < 16; i++) rks[r][i] = w[16*r+i];
  endtask

  task automatic ctr_xor_block(input vec_t v, output res_t o);
    logic [7:0] s [16];
    logic [7:0] t [16];
    logic [7:0] a0, a1, a2, a3, al, b;
    int n;
    n = (v.nb > 16) ? 16 : v.nb;
    if (v.newmsg) m_ctr = '0;
    o.lo = '0;
    o.hi = '0;
    o.nb = n[4:0];
    if (n == 0) return;
    for (int i = 0; i < 8; i++) begin
      s[i] = m_nonce[8*i +: 8];
      s[i+8] = m_ctr[8*i +: 8];
    end
    for (int i = 0; i < 16; i++) s[i] ^= rks[0][i];
    for (int r = 1; r <= 10; r++) begin
      for (int c = 0; c < 4; c++)
        for (int i = 0; i < 4; i++) t[4*c+i] = sb[s[4*((c+i)%4)+i]];
      if (r != 10) begin
        for (int c = 0; c < 4; c++) begin
          a0 = t[4*c]; a1 = t[4*c+1]; a2 = t[4*c+2]; a3 = t[4*c+3];
          al = a0 ^ a1 ^ a2 ^ a3;
          s[4*c]   = a0 ^ al ^ gmul2(a0 ^ a1);
          s[4*c+1] = a1 ^ al ^ gmul2(a1 ^ a2);
          s[4*c+2] = a2 ^ al ^ gmul2(a2 ^ a3);
          s[4*c+3] = a3 ^ al ^ gmul2(a3 ^ a0);
        end
      end else begin
        s = t;
      end
      for (int i = 0; i < 16; i++) s[i] ^= rks[r][i];
    end
    for (int i = 0; i < 16; i++) begin
      b = (i < 8) ? v.lo[8*i +: 8] : v.hi[8*(i-8) +: 8];
      b = (i < n) ? (b ^ s[i]) : 8'h00;
      if (i < 8) o.lo[8*i +: 8] = b;
      else o.hi[8*(i-8) +: 8] = b;
    end
    m_ctr++;
  endtask

  initial begin
    clk = 0;
    forever #10 clk = ~clk;
  end

  initial begin
    #20ms;
    $display("aes128_ctr_keystream_xor_unit: mismatch");
    $finish;
  end

  // mostly no gap, often a short one, now and then a long one
  function automatic int gap_len();
    int r;
    r = $urandom_range(0, 99);
    if (r < 55) return 0;
    if (r < 95) return $urandom_range(1, 3);
    return $urandom_range(10, 40);
  endfunction

  // receiver: stall for random stretches, check at rising edge
  initial begin
    res_t e;
    int stall;
    out_ready = 0;
    @(negedge clk);
    while (rst) @(negedge clk);
    forever begin
      stall = gap_len();
      if (stall != 0) begin
        out_ready = 0;
        repeat (stall) @(negedge clk);
      end
      out_ready = 1;
      @(posedge clk);
      if (out_valid && out_ready) begin
        if (pending_q.size() == 0) begin
          errors++;
          if (errors <= 10) $display("unexpected result %h %h %0d",
                                     result_high, result_low, result_bytes);
        end else begin
          e = pending_q.pop_front();
          if (e.lo !== result_low || e.hi !== result_high || e.nb !== result_bytes) begin
            errors++;
            if (errors <= 10)
              $display("result mismatch: exp %h_%h/%0d got %h_%h/%0d",
                       e.hi, e.lo, e.nb, result_high, result_low, result_bytes);
          end
        end
      end
      @(negedge clk);
    end
  end

  // valid stays up between back-to-back items; it drops only for a gap
  task automatic send_block(input vec_t v);
    res_t o;
    int g;
    g = gap_len();
    if (g != 0) begin
      in_valid <= 0;
      repeat (g) @(negedge clk);
    end
    in_valid <= 1;
    new_message <= v.newmsg;
    text_low <= v.lo;
    text_high <= v.hi;
    valid_bytes <= v.nb;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    ctr_xor_block(v, o);
    if (v.has_exp && (o.lo !== v.elo || o.hi !== v.ehi || o.nb !== v.enb)) begin
      errors++;
      if (errors <= 10) $display("predictor disagrees with table row %0d", sent);
    end
    pending_q.push_back(o);
    sent++;
    @(negedge clk);
  endtask

  task automatic write_reg(input logic [1:0] idx, input logic [63:0] val);
    cfg_write = 1;
    cfg_index = idx;
    cfg_data = val;
    @(negedge clk);
    cfg_write = 0;
    case (idx)
      REG_KEY_LOW:  begin m_key_lo = val; build_round_keys(); end
      REG_KEY_HIGH: begin m_key_hi = val; build_round_keys(); end
      REG_NONCE:    m_nonce = val;
      default: ;
    endcase
  endtask

  task automatic drain();
    in_valid <= 0;
    while (pending_q.size() != 0) @(negedge clk);
    repeat (14) @(negedge clk);
  endtask

  function automatic vec_t rand_vec(input logic nm, input logic [4:0] nb);
    vec_t v;
    v.newmsg = nm;
    v.lo = {$urandom, $urandom};
    v.hi = {$urandom, $urandom};
    v.nb = nb;
    v.has_exp = 0;
    return v;
  endfunction

  vec_t table_rows [$];

  initial begin
    vec_t v;
    int len;
    for (int i = 0; i < 256; i++) sb[i] = SBOX[i];
    errors = 0; sent = 0;
    rst = 1; cfg_write = 0; cfg_index = REG_KEY_LOW; cfg_data = '0;
    in_valid = 0; new_message = 0; text_low = '0; text_high = '0; valid_bytes = 5'd16;
    m_key_lo = '0; m_key_hi = '0; m_nonce = '0; m_ctr = '0;
    build_round_keys();
    repeat (3) @(negedge clk);
    rst = 0;

    // zero key, zero nonce, zero counter: keystream is AES-0(0) = 66e94bd4ef8a2c3b...
    table_rows.push_back('{1, 64'h0, 64'h0, 5'd16, 1,
                           64'h3b2c8aefd44be966, 64'h2e2b34ca59fa4c88, 5'd16});
    table_rows.push_back('{0, '1, '1, 5'd16, 0, 0, 0, 0});
    table_rows.push_back('{0, '1, '1, 5'd0, 1, 64'h0, 64'h0, 5'd0});    // zero count
    table_rows.push_back('{0, '1, '1, 5'd31, 0, 0, 0, 0});              // saturates
    table_rows.push_back('{0, '1, '1, 5'd17, 0, 0, 0, 0});
    table_rows.push_back('{0, '1, '1, 5'd1, 0, 0, 0, 0});               // short, not last
    table_rows.push_back('{0, '1, '1, 5'd8, 0, 0, 0, 0});
    table_rows.push_back('{0, '1, '1, 5'd9, 0, 0, 0, 0});
    table_rows.push_back('{1, '1, '1, 5'd0, 1, 64'h0, 64'h0, 5'd0});    // clear w/o advance
    table_rows.push_back('{0, 64'h0, 64'h0, 5'd15, 0, 0, 0, 0});
    table_rows.push_back('{1, 64'h5555aaaa5555aaaa, 64'haaaa5555aaaa5555, 5'd16, 0, 0, 0, 0});
    foreach (table_rows[i]) send_block(table_rows[i]);
    drain();

    // FIPS-197 style key, extreme nonce; counter wrap needs 2^64 blocks so
    // extremes come through the nonce and key instead
    write_reg(REG_KEY_LOW, 64'h0706050403020100);
    write_reg(REG_KEY_HIGH, 64'h0f0e0d0c0b0a0908);
    write_reg(REG_NONCE, '1);
    write_reg(2'd3, 64'hdeadbeefdeadbeef);  // unknown index, ignored
    for (int i = 0; i < 6; i++) send_block(rand_vec(i == 0, 5'(16 - i)));
    drain();
    write_reg(REG_KEY_LOW, '1);
    write_reg(REG_KEY_HIGH, '1);
    write_reg(REG_NONCE, '0);
    for (int i = 0; i < 6; i++) send_block(rand_vec(i == 3, 5'($urandom_range(0, 31))));
    drain();

    for (int ph = 0; ph < 6; ph++) begin
      write_reg(REG_KEY_LOW, {$urandom, $urandom});
      write_reg(REG_KEY_HIGH, {$urandom, $urandom});
      write_reg(REG_NONCE, {$urandom, $urandom});
      for (int m = 0; m < 38; m++) begin
        len = $urandom_range(1, 8);
        for (int k = 0; k < len; k++) begin
          // mostly full blocks, last block of 1 to 16 bytes; some noise
          if ($urandom_range(0, 9) == 0)
            v = rand_vec(1'($urandom_range(0, 1)), 5'($urandom_range(0, 31)));
          else
            v = rand_vec(k == 0, (k == len - 1) ? 5'($urandom_range(1, 16)) : 5'd16);
          send_block(v);
        end
      end
      drain();
    end

    if (errors == 0)
      $display("aes128_ctr_keystream_xor_unit: match");
    else
      $display("aes128_ctr_keystream_xor_unit: mismatch");
    $finish;
  end
endmodule
`default_nettype wire
